/* design/rhsi_pkg.sv */
// ----------------------------------------------------------------------------
// rhsi_pkg
// shared types, constants and step functions of the rgb to hsi pipeline
// ----------------------------------------------------------------------------
package rhsi_pkg;

   localparam int XW = 32;
   localparam int AW = 34;
   localparam int RW = 18;
   localparam int DW = 10;
   localparam int NSTAGE = 9;

   localparam logic signed [AW-1:0] ATAN_TURN [16] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10680862,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
   };

   localparam logic [17:0] SQRT3_Q16 = 18'd113512;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [AW-1:0] ang;
      logic [RW-1:0]        rem;
      logic [DW-1:0]        den;
      logic [7:0]           quo;
      logic                 fixed_hue;
      logic [7:0]           hue_fix;
      logic                 mirror;
      logic [7:0]           inten;
   } stage_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] inten;
   } result_type;

   function automatic stage_type cordic_iter(input stage_type s, input logic [3:0] i);
      stage_type            o;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      o  = s;
      xs = s.x >>> i;
      ys = s.y >>> i;
      if (s.y > 0) begin
         o.x   = s.x + ys;
         o.y   = s.y - xs;
         o.ang = s.ang + ATAN_TURN[i];
      end else begin
         o.x   = s.x - ys;
         o.y   = s.y + xs;
         o.ang = s.ang - ATAN_TURN[i];
      end
      return o;
   endfunction

   function automatic stage_type div_bit(input stage_type s, input logic [2:0] k);
      stage_type     o;
      logic [RW-1:0] trial;
      o     = s;
      trial = RW'(s.den) << k;
      if (s.rem >= trial) begin
         o.rem    = s.rem - trial;
         o.quo[k] = 1'b1;
      end
      return o;
   endfunction

endpackage

/* design/rhsi_if.sv */
// ----------------------------------------------------------------------------
// rhsi_req_if / rhsi_rsp_if
// pixel and result channels with valid/ready transfer
// ----------------------------------------------------------------------------
interface rhsi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   modport source (output valid, output blue, output green, output red, input ready);
   modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface rhsi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] hue_code;
   logic [7:0] saturation_code;
   logic [7:0] intensity_code;
   modport source (output valid, output hue_code, output saturation_code,
                   output intensity_code, input ready);
   modport sink   (input valid, input hue_code, input saturation_code,
                   input intensity_code, output ready);
endinterface

/* design/rgb_to_hsi_pixel_core.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel_core
// pixels pass through stage registers st_ff, then output register out_ff
// throughput: one pixel per cycle unless stalled, set by the stage chain
// each of 8 middle stages does two cordic rotations and one quotient bit
// stalls are absorbed per stage, empty stages fill while the output waits
// reset (synchronous, active high) clears all stage valid bits
// ----------------------------------------------------------------------------
module rgb_to_hsi_pixel_core (
   input logic       clock,
   input logic       reset,
   rhsi_req_if.sink  req,
   rhsi_rsp_if.source rsp
);
   import rhsi_pkg::*;

   stage_type          st_ff [NSTAGE];
   stage_type          st_in [NSTAGE];
   logic [NSTAGE-1:0]  v_ff;
   logic [NSTAGE:0]    ld;
   result_type         out_ff;
   result_type         out_in;
   logic               out_v_ff;

   logic [DW-1:0]        sum;
   logic [7:0]           mn;
   logic [7:0]           dgb;
   logic signed [10:0]   xi;
   logic signed [XW-1:0] x0;
   logic signed [XW-1:0] y0;
   logic [RW-1:0]        num;
   logic [19:0]          i3;
   stage_type            prep;

   always_comb begin
      sum = DW'(req.red) + DW'(req.green) + DW'(req.blue);
      mn  = req.red;
      if (req.green < mn) mn = req.green;
      if (req.blue < mn) mn = req.blue;
      dgb = (req.green > req.blue) ? req.green - req.blue : req.blue - req.green;
      xi  = 11'sd2 * $signed({3'b0, req.red}) - $signed({3'b0, req.green})
            - $signed({3'b0, req.blue});
      x0  = XW'(xi) <<< 16;
      y0  = $signed(XW'(dgb) * XW'(SQRT3_Q16));
      num = RW'((sum - DW'(3 * mn)) * 255);
      i3  = 20'(sum) * 20'd683;
      prep           = '0;
      prep.rem       = num;
      prep.den       = (sum == '0) ? DW'(1) : sum;
      prep.inten     = i3[18:11];
      prep.mirror    = req.blue > req.green;
      if (x0 < 0) begin
         prep.x   = y0;
         prep.y   = -x0;
         prep.ang = AW'(1) <<< 30;
      end else begin
         prep.x   = x0;
         prep.y   = y0;
      end
      if (req.green == req.blue) begin
         prep.fixed_hue = 1'b1;
         prep.hue_fix   = (req.red < req.green) ? 8'd127 : 8'd0;
      end else if (req.red == req.blue && req.green > req.red) begin
         prep.fixed_hue = 1'b1;
         prep.hue_fix   = 8'd85;
      end else if (req.red == req.green && req.blue > req.red) begin
         prep.fixed_hue = 1'b1;
         prep.hue_fix   = 8'd170;
      end
   end

   assign st_in[0] = prep;

   for (genvar k = 1; k < NSTAGE; k++) begin : g_stage
      assign st_in[k] = div_bit(cordic_iter(cordic_iter(st_ff[k-1], 4'(2*k-2)),
                                            4'(2*k-1)), 3'(NSTAGE-1-k));
   end

   logic signed [AW-1:0] angc;
   logic [32:0]          u;
   logic [40:0]          prod;

   always_comb begin
      angc = st_ff[NSTAGE-1].ang;
      if (angc < 0) angc = '0;
      if (angc > (AW'(1) <<< 31)) angc = AW'(1) <<< 31;
      u    = st_ff[NSTAGE-1].mirror ? (33'd1 << 32) - 33'(angc) : 33'(angc);
      prod = {u, 8'b0} - 41'(u);
      out_in.hue   = st_ff[NSTAGE-1].fixed_hue ? st_ff[NSTAGE-1].hue_fix : prod[39:32];
      out_in.sat   = st_ff[NSTAGE-1].quo;
      out_in.inten = st_ff[NSTAGE-1].inten;
   end

   always_comb begin
      ld[NSTAGE] = !out_v_ff || rsp.ready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
   end

   assign req.ready = ld[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (ld[0]) v_ff[0] <= req.valid;
         for (int k = 1; k < NSTAGE; k++) begin
            if (ld[k]) v_ff[k] <= v_ff[k-1];
         end
         if (ld[NSTAGE]) out_v_ff <= v_ff[NSTAGE-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTAGE; k++) begin
         if (ld[k]) st_ff[k] <= st_in[k];
      end
      if (ld[NSTAGE]) out_ff <= out_in;
   end

   assign rsp.valid           = out_v_ff;
   assign rsp.hue_code        = out_ff.hue;
   assign rsp.saturation_code = out_ff.sat;
   assign rsp.intensity_code  = out_ff.inten;

endmodule

/* design/rhsi_checker.sv */
// ----------------------------------------------------------------------------
// rhsi_checker
// port-level checks of the rgb to hsi pipeline, bound to the top level
// ----------------------------------------------------------------------------
module rhsi_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_hue_code,
   input logic [7:0] rsp_saturation_code,
   input logic [7:0] rsp_intensity_code
);
   logic [4:0] cnt_ff;
   logic [4:0] cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_valid && req_ready) cnt_in = cnt_in + 5'd1;
      if (rsp_valid && rsp_ready) cnt_in = cnt_in - 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   a_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 5'd10)
      else $error("too many pixels in flight");
   a_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 5'd0)
      else $error("result without pixel");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue_code)
         && $stable(rsp_saturation_code) && $stable(rsp_intensity_code))
      else $error("stalled result changed");

endmodule

bind rgb_to_hsi_pixel_core rhsi_checker u_rhsi_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req.valid),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_hue_code        (rsp.hue_code),
   .rsp_saturation_code (rsp.saturation_code),
   .rsp_intensity_code  (rsp.intensity_code)
);

/* dv/rhsi_tb_if.sv */
// ----------------------------------------------------------------------------
// rhsi_tb_pkg
// testbench-side note: channel interfaces come from the design folder
// ----------------------------------------------------------------------------
package rhsi_tb_pkg;

   typedef struct {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] inten;
   } hsi_code_type;

endpackage

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives bgr pixels into rgb_to_hsi_pixel_core with random idling on both
// channels and checks hue, saturation and intensity against a cordic predictor
// ----------------------------------------------------------------------------
module tb_top;
   import rhsi_tb_pkg::*;

   localparam int N_RANDOM = 500;
   localparam longint CYCLE_LIMIT = 200000;

   class hsi_scoreboard;
      hsi_code_type pending[$];
      int errors;
      int checked;

      function longint fshift(longint v, int s);
         if (v >= 0) return v >>> s;
         return -((-v - 1) >>> s) - 1;
      endfunction

      function logic [7:0] hue_angle(int r, int g, int b);
         longint x, y, ang, t, xs, ys;
         longint atab[16];
         longint unsigned u;
         int d;
         atab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                  10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                  83443, 41722, 20861};
         if (g == b) return (r < g) ? 8'd127 : 8'd0;
         if (r == b && g > r) return 8'd85;
         if (r == g && b > r) return 8'd170;
         d = (g > b) ? g - b : b - g;
         x = longint'(2 * r - g - b) * 65536;
         y = longint'(d) * 113512;
         ang = 0;
         if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            ang = 64'sd1 << 30;
         end
         for (int i = 0; i < 16; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0) begin
               x = x + ys;
               y = y - xs;
               ang += atab[i];
            end else begin
               x = x - ys;
               y = y + xs;
               ang -= atab[i];
            end
         end
         if (ang < 0) ang = 0;
         if (ang > (64'sd1 << 31)) ang = 64'sd1 << 31;
         u = (b > g) ? (64'd1 << 32) - ang : ang;
         return 8'((u * 255) >> 32);
      endfunction

      function void note_pixel(logic [7:0] b8, logic [7:0] g8, logic [7:0] r8);
         hsi_code_type e;
         int r, g, b, sum, mn;
         r = r8;
         g = g8;
         b = b8;
         sum = r + g + b;
         mn = r;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         e = '{8'd0, 8'd0, 8'd0};
         if (sum != 0) begin
            e.hue = hue_angle(r, g, b);
            e.sat = 8'((255 * (sum - 3 * mn)) / sum);
            e.inten = 8'(sum / 3);
         end
         pending.push_back(e);
      endfunction

      function void check_result(logic [7:0] h, logic [7:0] s, logic [7:0] i);
         hsi_code_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t unexpected result h=%0d s=%0d i=%0d", $time, h, s, i);
            return;
         end
         e = pending.pop_front();
         if (h !== e.hue) begin
            errors++;
            $display("%0t hue mismatch exp=%0d act=%0d", $time, e.hue, h);
         end
         if (s !== e.sat) begin
            errors++;
            $display("%0t saturation mismatch exp=%0d act=%0d", $time, e.sat, s);
         end
         if (i !== e.inten) begin
            errors++;
            $display("%0t intensity mismatch exp=%0d act=%0d", $time, e.inten, i);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   hsi_scoreboard board = new();

   rhsi_req_if req();
   rhsi_rsp_if rsp();

   rgb_to_hsi_pixel_core dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("rgb_to_hsi_pixel_core test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         board.note_pixel(req.blue, req.green, req.red);
      if (!reset && rsp.valid && rsp.ready)
         board.check_result(rsp.hue_code, rsp.saturation_code, rsp.intensity_code);
      if (reset)
         rsp.ready <= 1'b0;
      else
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.blue <= b;
      req.green <= g;
      req.red <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic send_random(int count);
      logic [7:0] b, g, r;
      for (int n = 0; n < count; n++) begin
         b = $urandom;
         g = $urandom;
         r = $urandom;
         case ($urandom_range(9))
            0: g = b;
            1: b = r;
            2: r = g;
            3: begin
               g = r;
               b = r;
            end
            default: ;
         endcase
         send_pixel(b, g, r);
      end
   endtask

   initial begin
      req.valid <= 1'b0;
      req.blue <= 8'd0;
      req.green <= 8'd0;
      req.red <= 8'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 61;
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd77, 8'd77, 8'd77);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd100, 8'd100, 8'd30);
      send_pixel(8'd100, 8'd100, 8'd200);
      send_pixel(8'd40, 8'd200, 8'd40);
      send_pixel(8'd200, 8'd40, 8'd40);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd254, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd170, 8'd85, 8'd255);
      send_pixel(8'd85, 8'd170, 8'd1);
      send_random(N_RANDOM / 3);
      send_idle_pct = 61;
      recv_idle_pct = 23;
      send_random(N_RANDOM / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(N_RANDOM - 2 * (N_RANDOM / 3));
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("covered %0d pixel results: extremes, gray, axis hues and random mixes",
               board.checked);
      $display("idling on sender, receiver, both and neither; %0d errors", board.errors);
      if (board.errors == 0)
         $display("rgb_to_hsi_pixel_core test passed");
      else
         $display("rgb_to_hsi_pixel_core test failed");
      $finish;
   end
endmodule

/* rgb_to_hsi_pixel_core.f */
design/rhsi_pkg.sv
design/rhsi_if.sv
design/rgb_to_hsi_pixel_core.sv
design/rhsi_checker.sv
dv/rhsi_tb_if.sv
dv/tb_top.sv
